/* rtl/wcsp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wcsp_pkg
// shared types and codes for the wav chunk stream parser
// ----------------------------------------------------------------------------
package wcsp_pkg;

  // chunk tags, little-endian as they arrive on the byte stream
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] FMT_PCM     = 16'd1;
  localparam logic [15:0] PCM_BITS    = 16'd16;
  localparam logic [31:0] FMT_TAKEN   = 32'd16;

  localparam logic [1:0] KIND_FORMAT = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_PREAMBLE  = 3'd1;
  localparam logic [2:0] ERR_NOT_PCM   = 3'd2;
  localparam logic [2:0] ERR_NOT_16BIT = 3'd3;
  localparam logic [2:0] ERR_NO_FMT    = 3'd4;
  localparam logic [2:0] ERR_NO_DATA   = 3'd5;
  localparam logic [2:0] ERR_TRUNCATED = 3'd6;

  localparam int OUTQ_DEPTH = 4;

  typedef enum logic [2:0] {
    PH_PRE,
    PH_HDR,
    PH_FMT,
    PH_SKIP,
    PH_PAD,
    PH_DATA
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] sample;
    logic [31:0] rate_hz;
    logic [15:0] channels;
    logic [2:0]  error_code;
    logic        last;
  } res_t;

  // results caused by one byte: none, one or two
  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] cnt;
  } pair_t;

  // queue entry: one or two results
  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } qent_t;

  function automatic res_t mk_res(logic [1:0] kind, logic [15:0] sample,
                                  logic [31:0] rate, logic [15:0] ch,
                                  logic [2:0] err, logic last);
    res_t r;
    r.kind        = kind;
    r.sample      = sample;
    r.rate_hz     = rate;
    r.channels    = ch;
    r.error_code  = err;
    r.last        = last;
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/wcsp_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wcsp_core
// parse state machine: one byte per step, up to two results per byte
// ----------------------------------------------------------------------------
module wcsp_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  wire logic [7:0]     data_byte,
  input  wire logic           end_of_file,
  output wcsp_pkg::pair_t     res
);
  import wcsp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic        fmt_seen_r, fmt_seen_nxt;
  logic [15:0] fcode_r, fcode_nxt;
  logic [15:0] bps_r, bps_nxt;
  logic [15:0] ch_r, ch_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [30:0] left_r, left_nxt;
  logic [7:0]  low_r, low_nxt;
  logic        fin_r, fin_nxt;

  // first result, end-of-samples flag, end-of-file error
  res_t        a_res;
  logic        a_v;
  logic        end_v;
  logic        eof_err_v;
  logic [2:0]  eof_code;
  res_t        end_res;
  res_t        eof_res;

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    tag_nxt      = tag_r;
    len_nxt      = len_r;
    skip_nxt     = skip_r;
    fmt_seen_nxt = fmt_seen_r;
    fcode_nxt    = fcode_r;
    bps_nxt      = bps_r;
    ch_nxt       = ch_r;
    rate_nxt     = rate_r;
    left_nxt     = left_r;
    low_nxt      = low_r;
    fin_nxt      = fin_r;
    a_res        = '0;
    a_v          = 1'b0;
    end_v        = 1'b0;

    if (!fin_r) begin
      unique case (phase_r)
        PH_PRE: begin
          if (pos_r < 4'd4 || (pos_r >= 4'd8 && pos_r < 4'd12))
            tag_nxt[{pos_r[1:0], 3'b000} +: 8] = data_byte;
          if (pos_r == 4'd3) begin
            if (tag_nxt != TAG_RIFF) begin
              a_res   = mk_res(KIND_ERROR, '0, '0, '0, ERR_PREAMBLE, 1'b1);
              a_v     = 1'b1;
              fin_nxt = 1'b1;
            end else begin
              tag_nxt = '0;
            end
          end
          if (!fin_nxt) begin
            if (pos_r >= 4'd11) begin
              if (tag_nxt != TAG_WAVE) begin
                a_res   = mk_res(KIND_ERROR, '0, '0, '0, ERR_PREAMBLE, 1'b1);
                a_v     = 1'b1;
                fin_nxt = 1'b1;
              end else begin
                phase_nxt = PH_HDR;
                pos_nxt   = '0;
                tag_nxt   = '0;
                len_nxt   = '0;
              end
            end else begin
              pos_nxt = pos_r + 4'd1;
            end
          end
        end

        PH_HDR: begin
          if (pos_r < 4'd4)
            tag_nxt[{pos_r[1:0], 3'b000} +: 8] = data_byte;
          else
            len_nxt[{pos_r[1:0], 3'b000} +: 8] = data_byte;
          if (pos_r >= 4'd7) begin
            pos_nxt = '0;
            if (tag_nxt == TAG_FMT) begin
              phase_nxt = PH_FMT;
              fcode_nxt = '0;
              ch_nxt    = '0;
              rate_nxt  = '0;
              bps_nxt   = '0;
            end else if (tag_nxt == TAG_DATA) begin
              if (!fmt_seen_r) begin
                a_res   = mk_res(KIND_ERROR, '0, '0, '0, ERR_NO_FMT, 1'b1);
                a_v     = 1'b1;
                fin_nxt = 1'b1;
              end else begin
                a_res    = mk_res(KIND_FORMAT, '0, rate_r, ch_r, ERR_NONE, 1'b0);
                a_v      = 1'b1;
                left_nxt = len_nxt[31:1];
                if (len_nxt[31:1] == '0) begin
                  end_v   = 1'b1;
                  fin_nxt = 1'b1;
                end else begin
                  phase_nxt = PH_DATA;
                end
              end
            end else if (len_nxt == '0) begin
              phase_nxt = PH_HDR;
              tag_nxt   = '0;
              len_nxt   = '0;
            end else begin
              skip_nxt  = len_nxt;
              phase_nxt = PH_SKIP;
            end
          end else begin
            pos_nxt = pos_r + 4'd1;
          end
        end

        PH_FMT: begin
          if (pos_r < 4'd2)
            fcode_nxt[{pos_r[0], 3'b000} +: 8] = data_byte;
          else if (pos_r < 4'd4)
            ch_nxt[{pos_r[0], 3'b000} +: 8] = data_byte;
          else if (pos_r < 4'd8)
            rate_nxt[{pos_r[1:0], 3'b000} +: 8] = data_byte;
          else if (pos_r >= 4'd14)
            bps_nxt[{pos_r[0], 3'b000} +: 8] = data_byte;
          if (pos_r >= 4'd15) begin
            if (fcode_nxt != FMT_PCM) begin
              a_res   = mk_res(KIND_ERROR, '0, '0, '0, ERR_NOT_PCM, 1'b1);
              a_v     = 1'b1;
              fin_nxt = 1'b1;
            end else if (bps_nxt != PCM_BITS) begin
              a_res   = mk_res(KIND_ERROR, '0, '0, '0, ERR_NOT_16BIT, 1'b1);
              a_v     = 1'b1;
              fin_nxt = 1'b1;
            end else begin
              fmt_seen_nxt = 1'b1;
              pos_nxt      = '0;
              if (len_r > FMT_TAKEN) begin
                skip_nxt  = len_r - FMT_TAKEN;
                phase_nxt = PH_SKIP;
              end else begin
                phase_nxt = PH_HDR;
                tag_nxt   = '0;
                len_nxt   = '0;
              end
            end
          end else begin
            pos_nxt = pos_r + 4'd1;
          end
        end

        PH_SKIP: begin
          skip_nxt = skip_r - {31'd0, (skip_r != '0)};
          if (skip_nxt == '0) begin
            // odd-length unknown chunks carry a pad byte, fmt extras do not
            if (tag_r != TAG_FMT && len_r[0]) begin
              phase_nxt = PH_PAD;
            end else begin
              phase_nxt = PH_HDR;
              pos_nxt   = '0;
              tag_nxt   = '0;
              len_nxt   = '0;
            end
          end
        end

        PH_PAD: begin
          phase_nxt = PH_HDR;
          pos_nxt   = '0;
          tag_nxt   = '0;
          len_nxt   = '0;
        end

        PH_DATA: begin
          if (!pos_r[0]) begin
            low_nxt = data_byte;
          end else begin
            a_res    = mk_res(KIND_SAMPLE, {data_byte, low_r}, '0, '0, ERR_NONE, 1'b0);
            a_v      = 1'b1;
            left_nxt = left_r - {30'd0, (left_r != '0)};
            if (left_nxt == '0) begin
              end_v   = 1'b1;
              fin_nxt = 1'b1;
            end
          end
          pos_nxt = {3'b000, ~pos_r[0]};
        end

        default: fin_nxt = 1'b1;
      endcase
    end
  end

  // error for a file that ends before parsing is complete
  always_comb begin
    eof_err_v = end_of_file && !fin_nxt;
    if (phase_nxt == PH_PRE)
      eof_code = ERR_PREAMBLE;
    else if (phase_nxt == PH_FMT)
      eof_code = ERR_NO_FMT;
    else if (phase_nxt == PH_DATA)
      eof_code = ERR_TRUNCATED;
    else if (fmt_seen_nxt)
      eof_code = ERR_NO_DATA;
    else
      eof_code = ERR_NO_FMT;
  end

  assign end_res = mk_res(KIND_END, '0, '0, '0, ERR_NONE, 1'b1);
  assign eof_res = mk_res(KIND_ERROR, '0, '0, '0, eof_code, 1'b1);

  // end-of-samples and end-of-file error never come together
  always_comb begin
    res.r0  = a_v ? a_res : eof_res;
    res.r1  = end_v ? end_res : eof_res;
    res.cnt = {1'b0, a_v} + {1'b0, (end_v || eof_err_v)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && end_of_file)) begin
      phase_r    <= PH_PRE;
      pos_r      <= '0;
      tag_r      <= '0;
      len_r      <= '0;
      skip_r     <= '0;
      fmt_seen_r <= 1'b0;
      fcode_r    <= '0;
      bps_r      <= '0;
      ch_r       <= '0;
      rate_r     <= '0;
      left_r     <= '0;
      low_r      <= '0;
      fin_r      <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      tag_r      <= tag_nxt;
      len_r      <= len_nxt;
      skip_r     <= skip_nxt;
      fmt_seen_r <= fmt_seen_nxt;
      fcode_r    <= fcode_nxt;
      bps_r      <= bps_nxt;
      ch_r       <= ch_nxt;
      rate_r     <= rate_nxt;
      left_r     <= left_nxt;
      low_r      <= low_nxt;
      fin_r      <= fin_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/wcsp_outq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wcsp_outq
// result queue: entries of one or two results, drained one result per word
// ----------------------------------------------------------------------------
module wcsp_outq #(
  parameter int DEPTH = wcsp_pkg::OUTQ_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire wcsp_pkg::pair_t push_pair,
  output logic                 full,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output wcsp_pkg::res_t       out_res
);
  import wcsp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  qent_t             mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              sub_r, sub_nxt;
  qent_t             head;
  logic              pop_word;
  logic              pop_entry;

  assign head      = mem_r[rd_ptr_r];
  assign out_valid = (count_r != '0);
  assign out_res   = sub_r ? head.r1 : head.r0;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_word  = out_valid && out_ready;
  assign pop_entry = pop_word && (sub_r || !head.two);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    sub_nxt    = sub_r;
    if (push)
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop_entry) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      sub_nxt    = 1'b0;
    end else if (pop_word) begin
      sub_nxt = 1'b1;
    end
    if (push && !pop_entry)
      count_nxt = count_r + 1'b1;
    else if (!push && pop_entry)
      count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      sub_r    <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      sub_r    <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r].r0  <= push_pair.r0;
      mem_r[wr_ptr_r].r1  <= push_pair.r1;
      mem_r[wr_ptr_r].two <= push_pair.cnt[1];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("result queue over capacity");

  a_second_word: assert property (@(posedge clk) disable iff (!rst_n)
    sub_r |-> (out_valid && head.two))
    else $error("second word taken from a single-result entry");

endmodule
`default_nettype wire

/* rtl/wav_chunk_stream_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wav_chunk_stream_parser
// byte-serial riff/wave pcm16 parser with format, sample and error results
// ----------------------------------------------------------------------------
// a byte's first result is offered once the byte has passed the input register
//   and the result has been written into the result queue
// throughput: one byte per cycle; results leave one word per cycle while out_ready
//   is high; a byte causing results holds the input only while the queue is full
// reset: rst_n low clears parse state and empties the queue; a byte marked
//   end_of_file also returns the parser to its reset state
module wav_chunk_stream_parser #(
  parameter int QUEUE_DEPTH = wcsp_pkg::OUTQ_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic               in_end_of_file,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_kind,
  output logic signed [15:0]      out_sample,
  output logic [31:0]             out_rate_hz,
  output logic [15:0]             out_channels,
  output logic [2:0]              out_error_code,
  output logic                    out_last
);
  import wcsp_pkg::*;

  // input register
  logic       item_valid_r, item_valid_nxt;
  logic [7:0] byte_r;
  logic       eof_r;

  pair_t      pair;
  logic       q_full;
  logic       step;
  res_t       head_res;

  // a byte that causes no result never waits on the queue
  assign step     = item_valid_r && ((pair.cnt == 2'd0) || !q_full);
  assign in_ready = !item_valid_r || step;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (in_valid && in_ready)
      item_valid_nxt = 1'b1;
    else if (step)
      item_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_data_byte;
      eof_r  <= in_end_of_file;
    end
  end

  // parse state and per-byte results
  wcsp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .data_byte   (byte_r),
    .end_of_file (eof_r),
    .res         (pair)
  );

  // results queued as one entry per byte that causes any
  wcsp_outq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step && (pair.cnt != 2'd0)),
    .push_pair (pair),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (head_res)
  );

  assign out_kind        = head_res.kind;
  assign out_sample      = $signed(head_res.sample);
  assign out_rate_hz     = head_res.rate_hz;
  assign out_channels    = head_res.channels;
  assign out_error_code  = head_res.error_code;
  assign out_last        = head_res.last;

  // only error and end-of-samples results close a file
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_kind == KIND_ERROR || out_kind == KIND_END))
    else $error("last flag on a non-terminal result");

  // an error result always carries a code
  a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_ERROR) |-> (out_error_code != ERR_NONE))
    else $error("error result without a code");

  // a taken byte is held in the input register the next cycle
  a_input_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> item_valid_r)
    else $error("accepted byte lost");

endmodule
`default_nettype wire

/* test/wav_chunk_stream_parser_checker.sv */
// ----------------------------------------------------------------------------
// wav_chunk_stream_parser_checker
// watches both channels of the wav parser, predicts the result words for
// every accepted byte and compares each result word field by field
// ----------------------------------------------------------------------------
module wav_chunk_stream_parser_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic               in_end_of_file,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic [1:0]         out_kind,
  input  wire logic signed [15:0] out_sample,
  input  wire logic [31:0]        out_rate_hz,
  input  wire logic [15:0]        out_channels,
  input  wire logic [2:0]         out_error_code,
  input  wire logic               out_last,
  output int                      mismatch_count,
  output int                      results_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import wcsp_pkg::*;

  // parser state as the predictor tracks it
  phase_t      phase;
  logic [31:0] pos;
  logic [31:0] tag;
  logic [31:0] clen;
  logic [31:0] skip_left;
  logic        fmt_ok;
  logic [15:0] fcode;
  logic [15:0] bits;
  logic [15:0] chans;
  logic [31:0] rate;
  logic [30:0] samples_left;
  logic [7:0]  lo;
  logic        finished;

  res_t wav_results_due[$];

  task automatic clear_parser();
    phase        = PH_PRE;
    pos          = '0;
    tag          = '0;
    clen         = '0;
    skip_left    = '0;
    fmt_ok       = 1'b0;
    fcode        = '0;
    bits         = '0;
    chans        = '0;
    rate         = '0;
    samples_left = '0;
    lo           = '0;
    finished     = 1'b0;
  endtask

  task automatic queue_result(input logic [1:0] kind, input logic [15:0] smp,
                              input logic [31:0] r, input logic [15:0] ch,
                              input logic [2:0] err, input logic last);
    res_t w;
    w.kind        = kind;
    w.sample      = smp;
    w.rate_hz     = r;
    w.channels    = ch;
    w.error_code  = err;
    w.last        = last;
    wav_results_due.push_back(w);
  endtask

  task automatic abort_file(input logic [2:0] code);
    queue_result(KIND_ERROR, '0, '0, '0, code, 1'b1);
    finished = 1'b1;
  endtask

  task automatic start_header();
    phase = PH_HDR;
    pos   = '0;
    tag   = '0;
    clen  = '0;
  endtask

  // fields are cleared on entry to each phase and written one byte at a time,
  // the same way as the parser does
  task automatic parse_wav_byte(input logic [7:0] b, input logic eof);
    logic [31:0] p;
    logic [2:0]  code;
    p = pos;
    if (!finished) begin
      case (phase)
        PH_PRE: begin
          if (p < 4 || (p >= 8 && p < 12)) tag[8*p[1:0] +: 8] = b;
          if (p == 3) begin
            if (tag != TAG_RIFF) abort_file(ERR_PREAMBLE);
            else tag = '0;
          end
          if (!finished) begin
            if (p >= 11) begin
              if (tag != TAG_WAVE) abort_file(ERR_PREAMBLE);
              else start_header();
            end else begin
              pos = p + 1;
            end
          end
        end
        PH_HDR: begin
          if (p < 4) tag[8*p[1:0] +: 8] = b;
          else if (p < 8) clen[8*p[1:0] +: 8] = b;
          if (p >= 7) begin
            pos = '0;
            if (tag == TAG_FMT) begin
              phase = PH_FMT;
              fcode = '0;
              chans = '0;
              rate  = '0;
              bits  = '0;
            end else if (tag == TAG_DATA) begin
              if (!fmt_ok) begin
                abort_file(ERR_NO_FMT);
              end else begin
                queue_result(KIND_FORMAT, '0, rate, chans, ERR_NONE, 1'b0);
                samples_left = clen[31:1];
                if (samples_left == 0) begin
                  queue_result(KIND_END, '0, '0, '0, ERR_NONE, 1'b1);
                  finished = 1'b1;
                end else begin
                  phase = PH_DATA;
                end
              end
            end else if (clen == 0) begin
              start_header();
            end else begin
              skip_left = clen;
              phase     = PH_SKIP;
            end
          end else begin
            pos = p + 1;
          end
        end
        PH_FMT: begin
          if (p < 2) fcode[8*p[0] +: 8] = b;
          else if (p < 4) chans[8*p[0] +: 8] = b;
          else if (p < 8) rate[8*p[1:0] +: 8] = b;
          else if (p >= 14 && p < 16) bits[8*p[0] +: 8] = b;
          if (p >= 15) begin
            if (fcode != FMT_PCM) begin
              abort_file(ERR_NOT_PCM);
            end else if (bits != PCM_BITS) begin
              abort_file(ERR_NOT_16BIT);
            end else begin
              fmt_ok = 1'b1;
              if (clen > FMT_TAKEN) begin
                skip_left = clen - FMT_TAKEN;
                phase     = PH_SKIP;
                pos       = '0;
              end else begin
                start_header();
              end
            end
          end else begin
            pos = p + 1;
          end
        end
        PH_SKIP: begin
          if (skip_left != 0) skip_left = skip_left - 1;
          if (skip_left == 0) begin
            // fmt leftovers carry no pad byte
            if (tag != TAG_FMT && clen[0]) phase = PH_PAD;
            else start_header();
          end
        end
        PH_PAD: start_header();
        PH_DATA: begin
          if (!p[0]) begin
            lo = b;
          end else begin
            queue_result(KIND_SAMPLE, {b, lo}, '0, '0, ERR_NONE, 1'b0);
            if (samples_left != 0) samples_left = samples_left - 31'd1;
            if (samples_left == 0) begin
              queue_result(KIND_END, '0, '0, '0, ERR_NONE, 1'b1);
              finished = 1'b1;
            end
          end
          pos = {31'd0, ~p[0]};
        end
        default: finished = 1'b1;
      endcase
    end
    if (eof) begin
      if (!finished) begin
        case (phase)
          PH_PRE:  code = ERR_PREAMBLE;
          PH_FMT:  code = ERR_NO_FMT;
          PH_DATA: code = ERR_TRUNCATED;
          default: code = fmt_ok ? ERR_NO_DATA : ERR_NO_FMT;
        endcase
        abort_file(code);
      end
      clear_parser();
    end
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t w;
    if (!rst_n) begin
      clear_parser();
      wav_results_due.delete();
    end else begin
      // results pass the input register and the result queue, so compare first
      if (out_valid && out_ready) begin
        if (wav_results_due.size() == 0) begin
          $error("result word with nothing due: kind %0d", out_kind);
          mismatch_count++;
        end else begin
          w = wav_results_due.pop_front();
          compare_field("kind", {30'd0, w.kind}, {30'd0, out_kind});
          compare_field("sample", {16'd0, w.sample}, {16'd0, out_sample});
          compare_field("rate_hz", w.rate_hz, out_rate_hz);
          compare_field("channels", {16'd0, w.channels}, {16'd0, out_channels});
          compare_field("error_code", {29'd0, w.error_code}, {29'd0, out_error_code});
          compare_field("last", {31'd0, w.last}, {31'd0, out_last});
        end
      end
      if (in_valid && in_ready) parse_wav_byte(in_data_byte, in_end_of_file);
    end
    results_pending <= wav_results_due.size();
  end

endmodule

/* test/wav_chunk_stream_parser_test.sv */
// ----------------------------------------------------------------------------
// wav_chunk_stream_parser_test
// feeds whole wav files byte by byte into the parser, directed corner cases
// first and then mostly well-formed random files, with random idling on both
// channels and one long receiver hold-off; the checker predicts and compares
// ----------------------------------------------------------------------------
module wav_chunk_stream_parser_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wcsp_pkg::*;

  localparam int BYTE_BUDGET  = 1850;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;

  // a chunk tag the parser does not know, "LIST" little-endian
  localparam logic [31:0] TAG_LIST = 32'h5453_494C;
  // preamble tags one letter off from the expected ones
  localparam logic [31:0] TAG_RIFX = 32'h5846_4952;
  localparam logic [31:0] TAG_WAVF = 32'h4656_4157;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_data_byte;
  logic               in_end_of_file;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_kind;
  logic signed [15:0] out_sample;
  logic [31:0]        out_rate_hz;
  logic [15:0]        out_channels;
  logic [2:0]         out_error_code;
  logic               out_last;

  int mismatch_count;
  int results_pending;
  int cycle_count;
  int bytes_sent;

  // handshake between the sender and the receiver processes
  bit quiet_tail;
  bit long_hold_req;
  bit long_hold_done;

  // byte image of the file under construction
  logic [7:0] wav_bytes[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  wav_chunk_stream_parser dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_end_of_file  (in_end_of_file),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_sample      (out_sample),
    .out_rate_hz     (out_rate_hz),
    .out_channels    (out_channels),
    .out_error_code  (out_error_code),
    .out_last        (out_last)
  );

  wav_chunk_stream_parser_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_end_of_file  (in_end_of_file),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_sample      (out_sample),
    .out_rate_hz     (out_rate_hz),
    .out_channels    (out_channels),
    .out_error_code  (out_error_code),
    .out_last        (out_last),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  // --- file building, all fields little-endian -----------------------------

  task automatic put_u16(input logic [15:0] v);
    wav_bytes.push_back(v[7:0]);
    wav_bytes.push_back(v[15:8]);
  endtask

  task automatic put_u32(input logic [31:0] v);
    put_u16(v[15:0]);
    put_u16(v[31:16]);
  endtask

  // riff tag, size field the parser ignores, wave tag
  task automatic put_preamble();
    put_u32(TAG_RIFF);
    put_u32($urandom);
    put_u32(TAG_WAVE);
  endtask

  // the parser always takes 16 body bytes, even when len says fewer,
  // so a short chunk still carries 16 bytes here
  task automatic put_fmt(input logic [15:0] code, input logic [15:0] ch,
                         input logic [31:0] r, input logic [15:0] nbits,
                         input int len);
    put_u32(TAG_FMT);
    put_u32(len);
    put_u16(code);
    put_u16(ch);
    put_u32(r);
    put_u32($urandom);
    put_u16(16'($urandom));
    put_u16(nbits);
    repeat ((len > 16) ? len - 16 : 0) wav_bytes.push_back(8'($urandom));
  endtask

  // unknown chunk with random body and its pad byte when odd
  task automatic put_chunk(input logic [31:0] tag, input int len);
    put_u32(tag);
    put_u32(len);
    repeat (len) wav_bytes.push_back(8'($urandom));
    if (len % 2 == 1) wav_bytes.push_back(8'($urandom));
  endtask

  // data header with the given length and nbytes of random sample bytes
  task automatic put_data(input logic [31:0] len, input int nbytes);
    put_u32(TAG_DATA);
    put_u32(len);
    repeat (nbytes) wav_bytes.push_back(8'($urandom));
  endtask

  // sends the whole file, end_of_file on its last byte; idle bursts fall
  // between words except during the long hold and the quiet tail
  task automatic send_wav();
    for (int i = 0; i < wav_bytes.size(); i++) begin
      if (!quiet_tail && !(long_hold_req && !long_hold_done) &&
          $urandom_range(0, 4) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      in_valid       <= 1'b1;
      in_data_byte   <= wav_bytes[i];
      in_end_of_file <= (i == wav_bytes.size() - 1);
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      bytes_sent++;
      if (bytes_sent == BYTE_BUDGET / 3) long_hold_req = 1'b1;
      if (bytes_sent >= BYTE_BUDGET * 85 / 100) quiet_tail = 1'b1;
    end
    wav_bytes.delete();
  endtask

  // --- stimulus and verdict ------------------------------------------------

  initial begin
    int n;
    int keep;
    int idx;
    int fmt_len;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_data_byte   <= '0;
    in_end_of_file <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // clean file with extreme format values and extreme samples
    put_preamble();
    put_fmt(FMT_PCM, 16'hFFFF, 32'hFFFF_FFFF, PCM_BITS, 16);
    put_data(8, 0);
    put_u16(16'h8000);
    put_u16(16'h7FFF);
    put_u16(16'h0000);
    put_u16(16'hFFFF);
    send_wav();

    // bad riff tag, the rest of the file is ignored
    put_u32(TAG_RIFX);
    put_u32($urandom);
    put_u32(TAG_WAVE);
    send_wav();

    // bad wave tag
    put_u32(TAG_RIFF);
    put_u32($urandom);
    put_u32(TAG_WAVF);
    send_wav();

    // end of file inside the preamble
    put_u32(TAG_RIFF);
    put_u16(16'($urandom));
    send_wav();

    // format code other than pcm
    put_preamble();
    put_fmt(16'd3, 16'd2, 32'd48000, PCM_BITS, 16);
    put_data(4, 4);
    send_wav();

    // 8-bit samples
    put_preamble();
    put_fmt(FMT_PCM, 16'd1, 32'd8000, 16'd8, 16);
    put_data(4, 4);
    send_wav();

    // data chunk with no fmt before it
    put_preamble();
    put_data(4, 4);
    send_wav();

    // end of file inside the fmt body
    put_preamble();
    put_u32(TAG_FMT);
    put_u32(16);
    repeat (5) wav_bytes.push_back(8'($urandom));
    send_wav();

    // odd unknown chunk with pad byte, file ends while scanning, no fmt yet
    put_preamble();
    put_chunk(TAG_LIST, 3);
    send_wav();

    // empty unknown chunk after fmt, file ends inside the next header
    put_preamble();
    put_fmt(FMT_PCM, 16'd0, 32'd0, PCM_BITS, 16);
    put_chunk(TAG_LIST, 0);
    put_u16(16'($urandom));
    put_u16(16'($urandom));
    send_wav();

    // short fmt, then a second fmt with one extra byte that wins,
    // odd unknown chunk, empty data chunk ending exactly at end of file
    put_preamble();
    put_fmt(FMT_PCM, 16'd1, 32'd11025, PCM_BITS, 4);
    put_fmt(FMT_PCM, 16'd2, 32'd22050, PCM_BITS, 17);
    put_chunk(TAG_LIST, 5);
    put_data(0, 0);
    send_wav();

    // odd data length: trailing byte and garbage after the end are ignored
    put_preamble();
    put_fmt(FMT_PCM, 16'd2, 32'd44100, PCM_BITS, 16);
    put_data(5, 5);
    repeat (3) wav_bytes.push_back(8'($urandom));
    send_wav();

    // truncated in the middle of the samples
    put_preamble();
    put_fmt(FMT_PCM, 16'd1, 32'd16000, PCM_BITS, 16);
    put_data(20, 7);
    send_wav();

    // unknown chunk with the largest odd length, file ends while skipping
    put_preamble();
    put_fmt(FMT_PCM, 16'd1, 32'd96000, PCM_BITS, 16);
    put_u32(TAG_LIST);
    put_u32(32'hFFFF_FFFF);
    repeat (6) wav_bytes.push_back(8'($urandom));
    send_wav();

    // end of file on the very byte that breaks the riff tag
    put_u32(TAG_RIFX);
    send_wav();

    // end of file on the byte that completes the last sample
    put_preamble();
    put_fmt(FMT_PCM, 16'd1, 32'd8000, PCM_BITS, 16);
    put_data(4, 4);
    send_wav();

    // a lone byte
    wav_bytes.push_back(8'($urandom));
    send_wav();

    // random files, mostly well-formed so that samples are reached
    while (bytes_sent < BYTE_BUDGET) begin
      if ($urandom_range(0, 9) < 8) begin
        put_preamble();
        repeat ($urandom_range(0, 1)) put_chunk($urandom, $urandom_range(0, 9));
        fmt_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 21) : 16;
        put_fmt(16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : FMT_PCM),
                16'($urandom), $urandom,
                16'(($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : PCM_BITS),
                fmt_len);
        // a repeated fmt overrides the first
        if ($urandom_range(0, 5) == 0)
          put_fmt(FMT_PCM, 16'($urandom), $urandom, PCM_BITS, 16);
        repeat ($urandom_range(0, 1)) put_chunk($urandom, $urandom_range(0, 9));
        n = $urandom_range(0, 40);
        put_data(n, n);
        repeat ($urandom_range(0, 2)) wav_bytes.push_back(8'($urandom));
        // now and then the file is cut short anywhere
        if ($urandom_range(0, 6) == 0) begin
          keep = $urandom_range(1, wav_bytes.size());
          while (wav_bytes.size() > keep) void'(wav_bytes.pop_back());
        end
      end else begin
        case ($urandom_range(0, 2))
          0: repeat ($urandom_range(1, 20)) wav_bytes.push_back(8'($urandom));
          1: begin
            // one bit flipped in the preamble
            put_preamble();
            idx = $urandom_range(0, 11);
            wav_bytes[idx] = wav_bytes[idx] ^ (8'd1 << $urandom_range(0, 7));
            repeat ($urandom_range(0, 12)) wav_bytes.push_back(8'($urandom));
          end
          default: begin
            // huge chunk length, the file ends long before the chunk does
            put_preamble();
            put_fmt(FMT_PCM, 16'($urandom), $urandom, PCM_BITS, 16);
            put_u32($urandom_range(0, 1) ? TAG_DATA : TAG_LIST);
            put_u32($urandom | 32'h8000_0000);
            repeat ($urandom_range(0, 12)) wav_bytes.push_back(8'($urandom));
          end
        endcase
      end
      send_wav();
    end

    // let every due result word arrive, then keep idling before the verdict
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // result side: random stall bursts, one long hold-off while the sender
  // keeps offering words, and no stalls in the quiet tail
  initial begin
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (long_hold_req && !long_hold_done) begin
        out_ready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
        long_hold_done = 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/wcsp_pkg.sv
rtl/wcsp_core.sv
rtl/wcsp_outq.sv
rtl/wav_chunk_stream_parser.sv
test/wav_chunk_stream_parser_checker.sv
test/wav_chunk_stream_parser_test.sv
